/* rtl/rrts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and codes for the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;
  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_TEARDOWN = 3'd1;
  localparam logic [2:0] CMD_RELEASE  = 3'd2;
  localparam logic [2:0] CMD_SCHEDULE = 3'd3;
  localparam logic [2:0] CMD_BLOCK    = 3'd4;
  localparam logic [2:0] CMD_WAKE     = 3'd5;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_FULL        = 3'd1;
  localparam logic [2:0] STS_EMPTY_SLOT  = 3'd2;
  localparam logic [2:0] STS_NOT_BLOCKED = 3'd3;
  localparam logic [2:0] STS_NOT_RUNNING = 3'd4;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture command word
    logic scan_init; // reset scan counter, prepare read
    logic scan_step; // evaluate current entry, advance
    logic finish;    // apply single-slot updates and emit
    logic clear;     // clearing pass write
  } rrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic clear_done;
  } rrts_sts_t;
endpackage

/* rtl/rrts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// command sequencer: clear pass, load, scan, finish
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output rrts_pkg::rrts_cmd_t cmd,
  input  rrts_pkg::rrts_sts_t sts
);
  import rrts_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.scan_init = 1'b1;
        state_next = sts.needs_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/rrts_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp
// task table memory, per-cpu registers and scan datapath
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int NUM_SLOTS = 128,
  parameter int NUM_CPUS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  rrts_pkg::rrts_cmd_t cmd,
  output rrts_pkg::rrts_sts_t sts,
  input  logic [2:0]        command,
  input  logic [2:0]        cpu_id,
  input  logic [6:0]        slot,
  output logic              strobe,
  output logic [2:0]        status_code,
  output logic [6:0]        chosen_slot,
  output logic              went_idle
);
  import rrts_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int EW = 7; // used, state(2), bound, owner(3)

  // entry: {used, state, bound, owner}
  logic [EW-1:0] mem [NUM_SLOTS];
  logic [EW-1:0] rd;
  logic [SW-1:0] raddr;
  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [6:0] cur_slot [NUM_CPUS];
  logic [NUM_CPUS-1:0] cpu_idle;
  logic [SW-1:0] scan_ptr;

  logic [2:0] op;
  logic [2:0] cpu;
  logic [6:0] tslot;
  logic [SW:0] cnt;      // entries evaluated
  logic [SW-1:0] idx;    // address being read
  logic        found;
  logic [SW-1:0] found_idx;
  logic [SW-1:0] free_idx;
  logic        free_found;
  logic        cur_fixed;  // schedule: current task already returned to ready
  logic        cpu_ok;
  logic [CW-1:0] cpu_c;
  logic        tslot_ok;
  logic [SW-1:0] tslot_c;
  logic [6:0]  cur;
  logic        cur_ok;
  logic [SW-1:0] cur_c;
  logic        sched_cur;
  logic [1:0]  eff_st;

  assign cpu_ok   = {29'd0, cpu} < NUM_CPUS;
  assign cpu_c    = cpu[CW-1:0];
  assign tslot_ok = {25'd0, tslot} < NUM_SLOTS;
  assign tslot_c  = SW'(tslot);
  assign cur      = cur_slot[cpu_c];
  assign cur_ok   = {25'd0, cur} < NUM_SLOTS;
  assign cur_c    = SW'(cur);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // entry fields of registered read
  logic       e_used, e_bound;
  logic [1:0] e_st;
  logic [2:0] e_own;
  assign e_used  = rd[6];
  assign e_st    = rd[5:4];
  assign e_bound = rd[3];
  assign e_own   = rd[2:0];

  assign sts.needs_scan = (op == CMD_CREATE) || (cpu_ok &&
                          (op == CMD_RELEASE || op == CMD_SCHEDULE));
  assign sts.clear_done = (cnt == (SW+1)'(NUM_SLOTS - 1));
  // registered read: address leads evaluation
  logic       rd_valid;
  logic [SW-1:0] rd_idx;
  assign sts.scan_done = rd_valid && ((cnt == (SW+1)'(NUM_SLOTS - 1)) ||
                         (op == CMD_CREATE && !e_used) ||
                         (op == CMD_SCHEDULE && e_used && eff_st == ST_READY &&
                          (!e_bound || e_own == cpu)));

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
    logic [SW:0] s;
    s = {1'b0, v} + 1'b1;
    wrap_inc = (s == (SW+1)'(NUM_SLOTS)) ? '0 : s[SW-1:0];
  endfunction

  // read address selection
  always_comb begin
    raddr = idx;
    if (cmd.load) raddr = (command == CMD_SCHEDULE) ? SW'(cur_slot[cpu_id[CW-1:0]]) :
                                                       SW'(slot);
    else if (cmd.scan_init) raddr = (op == CMD_SCHEDULE) ? scan_ptr :
                                    (op == CMD_BLOCK) ? cur_c :
                                    (op == CMD_TEARDOWN || op == CMD_WAKE) ? tslot_c : '0;
    else if (cmd.scan_step) raddr = wrap_inc(idx);
  end

  // scan stage write (release unbinds the cpu's bound entries other than its running current)
  logic scan_we;
  logic [EW-1:0] scan_wd;
  always_comb begin
    scan_we = 1'b0;
    scan_wd = rd;
    if (cmd.scan_step && rd_valid) begin
      if (op == CMD_RELEASE && e_used && e_bound && e_own == cpu &&
          !(!cpu_idle[cpu_c] && cur_c == rd_idx && cur_ok)) begin
        scan_we = 1'b1;
        scan_wd = {e_used, e_st, 1'b0, 3'd0};
      end
    end
  end

  // schedule current entry in ready state: treat running current as ready
  assign sched_cur = !cur_fixed && !cpu_idle[cpu_c] && cur_ok && cur_c == rd_idx;

  // finish stage decisions
  logic [2:0] f_code;
  logic [6:0] f_chosen;
  logic       f_idle;
  logic       f_we;
  logic [SW-1:0] f_wa;
  logic [EW-1:0] f_wd;
  always_comb begin
    f_code = STS_OK; f_chosen = '0; f_idle = 1'b0;
    f_we = 1'b0; f_wa = tslot_c; f_wd = rd;
    case (op)
      CMD_CREATE: begin
        if (free_found) begin
          f_chosen = 7'(free_idx);
          f_we = 1'b1; f_wa = free_idx; f_wd = {1'b1, ST_READY, 1'b0, 3'd0};
        end else f_code = STS_FULL;
      end
      CMD_TEARDOWN: begin
        if (!tslot_ok || !e_used) f_code = STS_EMPTY_SLOT;
        else begin f_we = 1'b1; f_wd = '0; end
      end
      CMD_SCHEDULE: begin
        if (!cpu_ok) f_code = STS_NOT_RUNNING;
        else if (found) begin
          f_chosen = 7'(found_idx);
          f_we = 1'b1; f_wa = found_idx;
          f_wd = {1'b1, ST_RUNNING, 1'b1, cpu};
        end else f_idle = 1'b1;
      end
      CMD_BLOCK: begin
        if (!cpu_ok || cpu_idle[cpu_c] || !cur_ok || !e_used || e_st != ST_RUNNING)
          f_code = STS_NOT_RUNNING;
        else begin
          f_we = 1'b1; f_wa = cur_c; f_wd = {rd[6], ST_BLOCKED, rd[3:0]};
        end
      end
      CMD_WAKE: begin
        if (!tslot_ok || !e_used) f_code = STS_EMPTY_SLOT;
        else if (e_st != ST_BLOCKED) f_code = STS_NOT_BLOCKED;
        else begin f_we = 1'b1; f_wd = {rd[6], ST_READY, rd[3:0]}; end
      end
      default: ;
    endcase
  end

  // schedule returns the running current task to ready before the scan
  logic fix_we;
  assign fix_we = cmd.scan_init && op == CMD_SCHEDULE && cpu_ok && !cpu_idle[cpu_c] &&
                  cur_ok && e_used && e_st == ST_RUNNING;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    if (cmd.clear) begin we = 1'b1; waddr = cnt[SW-1:0]; end
    else if (fix_we) begin we = 1'b1; waddr = cur_c; wdata = {rd[6], ST_READY, rd[3:0]}; end
    else if (scan_we) begin we = 1'b1; waddr = rd_idx; wdata = scan_wd; end
    else if (cmd.scan_step && op == CMD_SCHEDULE && rd_valid && sched_cur &&
             e_used && e_st == ST_RUNNING) begin
      we = 1'b1; waddr = rd_idx; wdata = {rd[6], ST_READY, rd[3:0]};
    end
    else if (cmd.finish) begin we = f_we; waddr = f_wa; wdata = f_wd; end
  end

  // effective state of scanned entry for schedule
  assign eff_st = (sched_cur && e_used && e_st == ST_RUNNING) ? ST_READY : e_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      cnt <= '0;
      scan_ptr <= '0;
      cpu_idle <= '1;
      rd_valid <= 1'b0;
      for (int c = 0; c < NUM_CPUS; c++) cur_slot[c] <= '0;
    end else begin
      strobe <= cmd.finish;
      if (cmd.clear) cnt <= cnt + 1'b1;
      if (cmd.load) begin
        op <= command; cpu <= cpu_id; tslot <= slot;
      end
      if (cmd.scan_init) begin
        cnt <= '0;
        idx <= raddr;
        rd_valid <= sts.needs_scan;
        found <= 1'b0; free_found <= 1'b0;
        cur_fixed <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx <= raddr;
        cnt <= cnt + 1'b1;
        rd_idx <= raddr;
        if (op == CMD_CREATE && !e_used) begin
          free_found <= 1'b1; free_idx <= rd_idx;
        end
        if (op == CMD_SCHEDULE && e_used && eff_st == ST_READY &&
            (!e_bound || e_own == cpu)) begin
          found <= 1'b1; found_idx <= rd_idx;
        end
        if (sts.scan_done) rd_valid <= 1'b0;
      end
      if (cmd.scan_init) rd_idx <= raddr;
      if (cmd.finish) begin
        status_code <= f_code; chosen_slot <= f_chosen; went_idle <= f_idle;
        if (op == CMD_TEARDOWN && tslot_ok && e_used)
          for (int c = 0; c < NUM_CPUS; c++)
            if (!cpu_idle[c] && cur_slot[c] == tslot) begin
              cpu_idle[c] <= 1'b1; cur_slot[c] <= '0;
            end
        if (op == CMD_SCHEDULE && cpu_ok) begin
          if (found) begin
            cur_slot[cpu_c] <= 7'(found_idx);
            cpu_idle[cpu_c] <= 1'b0;
            scan_ptr <= wrap_inc(found_idx);
          end else begin
            cur_slot[cpu_c] <= '0;
            cpu_idle[cpu_c] <= 1'b1;
          end
        end
      end
    end
  end
endmodule

/* rtl/round_robin_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// task table with per-cpu current task and round-robin affinity scheduling
// ----------------------------------------------------------------------------
// create, release and schedule walk the table one slot a cycle (release and schedule
//   only for a valid cpu); teardown, block and wake read a single entry and finish
// throughput: one command at a time, busy high until its word is emitted
// reset: a clearing pass writes every table entry to zero, busy high
// results are strobed for one cycle and cannot be stalled
module round_robin_task_scheduler #(
  parameter int NUM_SLOTS = 128,
  parameter int NUM_CPUS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command,
  input  logic [2:0] cpu_id,
  input  logic [6:0] slot,
  output logic       strobe,
  output logic [2:0] status_code,
  output logic [6:0] chosen_slot,
  output logic       went_idle
);
  import rrts_pkg::*;

  rrts_cmd_t cmd; // sequencer commands
  rrts_sts_t sts; // datapath status

  rrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  // table memory, cpu registers and scan pointer live in the datapath
  rrts_dp #(.NUM_SLOTS(NUM_SLOTS), .NUM_CPUS(NUM_CPUS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .command(command), .cpu_id(cpu_id), .slot(slot),
    .strobe(strobe), .status_code(status_code),
    .chosen_slot(chosen_slot), .went_idle(went_idle)
  );
endmodule

/* rtl/rrts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// port-level checks for the scheduler
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [2:0] status_code,
  input logic [6:0] chosen_slot,
  input logic       went_idle
);
  import rrts_pkg::*;

  a_code: assert property (@(posedge clk) disable iff (rst)
    strobe |-> status_code <= STS_NOT_RUNNING) else $error("bad status");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && went_idle |-> chosen_slot == 7'd0 && status_code == STS_OK)
    else $error("idle word");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy");
  a_strb: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !$past(strobe)) else $error("double word");
endmodule

bind round_robin_task_scheduler rrts_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .status_code(status_code), .chosen_slot(chosen_slot), .went_idle(went_idle)
);
